// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mts_pkg.sv -----
// constants and types of the min tracking stack
package mts_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

// ----- hdl/mts_ram.sv -----
// simple dual port ram with registered read
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/min_tracking_stack.sv -----
// min tracking stack top level: value and minimum stores with cached tops
//
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    tdata: push_value  tuser: cmd
//  m_axis   out  m_axis_tvalid/tready    tdata: top, min    tuser: is_empty, status
//
// a push, a refused push and a pop on empty load the result from the idle state
// a pop goes via the read state: registered reads of each store that was popped
// s_axis_tready is low in the read cycle of a pop and while a result waits unaccepted
// reset clears the counts and the output valid; the stores are not cleared
module min_tracking_stack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [mts_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] push_value
    input  logic [0:0]                 s_axis_tuser,   // [0] cmd
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [2*mts_pkg::DATA_W-1:0] m_axis_tdata, // [31:0] top_value, [63:32] min_value
    output logic [2:0]                 m_axis_tuser    // [0] is_empty, [2:1] status
);

    import mts_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_vcount, n_vcount;
    logic [CNT_W-1:0]  r_mcount, n_mcount;
    logic [DATA_W-1:0] r_top, n_top;
    logic [DATA_W-1:0] r_min, n_min;
    logic              r_min_pop, n_min_pop;

    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_top, n_out_top;
    logic [DATA_W-1:0] r_out_min, n_out_min;
    logic              r_out_empty, n_out_empty;
    t_status           r_out_status, n_out_status;
    logic              out_load;

    logic              in_acc;
    logic              cmd_pop;
    logic signed [DATA_W-1:0] push_value;

    logic              v_we, m_we, v_re, m_re;
    logic [ADDR_W-1:0] v_waddr, m_waddr, v_raddr, m_raddr;
    logic [DATA_W-1:0] v_rdata, m_rdata;
    logic [CNT_W-1:0]  v_rd_cnt, m_rd_cnt;

    assign cmd_pop       = (s_axis_tuser[0] == CMD_POP);
    assign push_value    = s_axis_tdata;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign v_rd_cnt = CNT_W'(r_vcount - CNT_W'(2));
    assign m_rd_cnt = CNT_W'(r_mcount - CNT_W'(2));
    assign v_raddr  = v_rd_cnt[ADDR_W-1:0];
    assign m_raddr  = m_rd_cnt[ADDR_W-1:0];
    assign v_waddr  = r_vcount[ADDR_W-1:0];
    assign m_waddr  = r_mcount[ADDR_W-1:0];

    mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (v_re),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && cmd_pop && (r_vcount != '0)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_vcount     = r_vcount;
        n_mcount     = r_mcount;
        n_top        = r_top;
        n_min        = r_min;
        n_min_pop    = r_min_pop;
        v_we         = 1'b0;
        m_we         = 1'b0;
        v_re         = 1'b0;
        m_re         = 1'b0;
        out_load     = 1'b0;
        n_out_top    = r_out_top;
        n_out_min    = r_out_min;
        n_out_empty  = r_out_empty;
        n_out_status = r_out_status;
        case (r_state)
            S_IDLE: begin
                if (in_acc && !cmd_pop) begin
                    out_load = 1'b1;
                    if (r_vcount == CNT_W'(DEPTH)) begin
                        n_out_top    = r_top;
                        n_out_min    = r_min;
                        n_out_empty  = 1'b0;
                        n_out_status = ST_FULL;
                    end else begin
                        v_we     = 1'b1;
                        n_vcount = CNT_W'(r_vcount + CNT_W'(1));
                        n_top    = push_value;
                        if ((r_mcount == '0) || (push_value <= $signed(r_min))) begin
                            m_we     = 1'b1;
                            n_mcount = CNT_W'(r_mcount + CNT_W'(1));
                            n_min    = push_value;
                        end
                        n_out_top    = push_value;
                        n_out_min    = n_min;
                        n_out_empty  = 1'b0;
                        n_out_status = ST_DONE;
                    end
                end else if (in_acc && cmd_pop) begin
                    if (r_vcount == '0) begin
                        out_load     = 1'b1;
                        n_out_top    = ALL_ONES;
                        n_out_min    = ALL_ONES;
                        n_out_empty  = 1'b1;
                        n_out_status = ST_EMPTY;
                    end else begin
                        v_re      = 1'b1;
                        n_vcount  = CNT_W'(r_vcount - CNT_W'(1));
                        n_min_pop = (r_mcount != '0) && (r_top == r_min);
                        if (n_min_pop) begin
                            m_re     = 1'b1;
                            n_mcount = CNT_W'(r_mcount - CNT_W'(1));
                        end
                    end
                end
            end
            S_READ: begin
                out_load = 1'b1;
                if (r_vcount == '0) begin
                    n_top = ALL_ONES;
                    n_min = ALL_ONES;
                end else begin
                    n_top = v_rdata;
                    if (r_min_pop) begin
                        n_min = (r_mcount == '0) ? ALL_ONES : m_rdata;
                    end
                end
                n_out_top    = n_top;
                n_out_min    = n_min;
                n_out_empty  = (r_vcount == '0);
                n_out_status = ST_DONE;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= '0;
            r_mcount    <= '0;
            r_min_pop   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcount    <= n_vcount;
            r_mcount    <= n_mcount;
            r_min_pop   <= n_min_pop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_min        <= n_min;
        r_out_top    <= n_out_top;
        r_out_min    <= n_out_min;
        r_out_empty  <= n_out_empty;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_min, r_out_top};
    assign m_axis_tuser  = {r_out_status, r_out_empty};

endmodule

// ----- hdl/mts_checker.sv -----
// port level checks of the min tracking stack and their binding
`include "assert_macros.svh"

module mts_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [2*mts_pkg::DATA_W-1:0] m_axis_tdata,
    input logic [2:0]                   m_axis_tuser
);

    import mts_pkg::*;

    logic              out_empty;
    logic [1:0]        out_status;
    logic [DATA_W-1:0] out_top;
    logic [DATA_W-1:0] out_min;

    assign out_empty  = m_axis_tuser[0];
    assign out_status = m_axis_tuser[2:1];
    assign out_top    = m_axis_tdata[DATA_W-1:0];
    assign out_min    = m_axis_tdata[2*DATA_W-1:DATA_W];

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    `ASSERT_IMPLIES(a_empty_ones, i_clk, i_rst_n, m_axis_tvalid && out_empty, (out_top == ALL_ONES) && (out_min == ALL_ONES), "empty result without all ones")
    `ASSERT_IMPLIES(a_full_nonempty, i_clk, i_rst_n, m_axis_tvalid && (out_status == ST_FULL), !out_empty, "refused push on an empty stack")
    `ASSERT_IMPLIES(a_pop_empty, i_clk, i_rst_n, m_axis_tvalid && (out_status == ST_EMPTY), out_empty, "ignored pop with elements left")
    `ASSERT_IMPLIES(a_min_le_top, i_clk, i_rst_n, m_axis_tvalid && !out_empty, $signed(out_min) <= $signed(out_top), "minimum above top")

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb.sv -----
// testbench of the min tracking stack: directed and random push and pop traffic
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [DATA_W-1:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_NEG = 32'h8000_0000;

    typedef struct {
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] min;
        logic              empty;
        t_status           status;
    } t_stack_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;      // [31:0] push_value
    logic [0:0] s_axis_tuser = '0;             // [0] cmd
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b1;
    logic [2*DATA_W-1:0] m_axis_tdata;         // [31:0] top_value, [63:32] min_value
    logic [2:0] m_axis_tuser;                  // [0] is_empty, [2:1] status

    logic signed [DATA_W-1:0] stack_vals[$];
    logic signed [DATA_W-1:0] stack_mins[$];
    t_stack_result predicted_results[$];
    t_stack_result exp_result;

    int fail_count = 0;
    int items_sent = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    bit idle_en = 1'b1;

    min_tracking_stack u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_stack_result apply_stack_op(input logic cmd,
                                                     input logic [DATA_W-1:0] value);
        t_stack_result res;
        logic signed [DATA_W-1:0] popped;
        res.status = ST_DONE;
        if (cmd == CMD_PUSH) begin
            if (stack_vals.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                if (stack_mins.size() == 0 ||
                    $signed(value) <= stack_mins[stack_mins.size()-1]) begin
                    stack_mins.push_back(value);
                end
                stack_vals.push_back(value);
            end
        end else begin
            if (stack_vals.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                popped = stack_vals.pop_back();
                if (stack_mins.size() != 0 && popped == stack_mins[stack_mins.size()-1]) begin
                    void'(stack_mins.pop_back());
                end
            end
        end
        res.top   = (stack_vals.size() != 0) ? stack_vals[stack_vals.size()-1] : ALL_ONES;
        res.min   = (stack_mins.size() != 0) ? stack_mins[stack_mins.size()-1] : ALL_ONES;
        res.empty = (stack_vals.size() == 0);
        return res;
    endfunction

    // mix of full range, small, extreme and near-minimum values
    function automatic logic [DATA_W-1:0] rand_push_value();
        logic [DATA_W-1:0] cur_min;
        cur_min = (stack_mins.size() != 0) ? stack_mins[stack_mins.size()-1] : '0;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 16) - 8;
            2: return cur_min;
            3: begin
                case ($urandom_range(0, 3))
                    0: return MAX_POS;
                    1: return MIN_NEG;
                    2: return '0;
                    default: return ALL_ONES;
                endcase
            end
            default: return cur_min + $urandom_range(0, 4) - 2;
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [DATA_W-1:0] value);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted_results.push_back(apply_stack_op(cmd, value));
        items_sent++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] expected,
                               input logic [DATA_W-1:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %h, actual %h", name, expected, actual);
            fail_count++;
        end
    endtask

    task automatic test_directed();
        send_item(CMD_POP, $urandom);
        send_item(CMD_PUSH, '0);
        send_item(CMD_PUSH, MAX_POS);
        send_item(CMD_PUSH, MIN_NEG);
        send_item(CMD_PUSH, MIN_NEG);
        send_item(CMD_PUSH, ALL_ONES);
        send_item(CMD_PUSH, 32'hAAAA_AAAA);
        send_item(CMD_PUSH, 32'h5555_5555);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_PUSH, 32'd5);
        send_item(CMD_PUSH, '0);
        send_item(CMD_PUSH, '0);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
    endtask

    task automatic test_fill_overflow();
        while (stack_vals.size() < DEPTH) send_item(CMD_PUSH, rand_push_value());
        repeat (4) send_item(CMD_PUSH, rand_push_value());
    endtask

    task automatic test_drain_underflow();
        while (stack_vals.size() != 0) send_item(CMD_POP, $urandom);
        repeat (3) send_item(CMD_POP, $urandom);
    endtask

    task automatic test_random_walk(input int n, input int push_pct);
        repeat (n) begin
            if ($urandom_range(0, 99) < push_pct) send_item(CMD_PUSH, rand_push_value());
            else send_item(CMD_POP, $urandom);
        end
    endtask

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_results.size() == 0) begin
                $error("result transaction with no expectation pending");
                fail_count++;
            end else begin
                exp_result = predicted_results.pop_front();
                check_field("top_value", exp_result.top, m_axis_tdata[DATA_W-1:0]);
                check_field("min_value", exp_result.min, m_axis_tdata[2*DATA_W-1:DATA_W]);
                check_field("is_empty", DATA_W'(exp_result.empty), DATA_W'(m_axis_tuser[0]));
                check_field("status", DATA_W'(exp_result.status), DATA_W'(m_axis_tuser[2:1]));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_overflow();
        test_drain_underflow();
        test_random_walk(100, 75);
        test_random_walk(100, 40);
        test_fill_overflow();
        test_random_walk(100, 30);
        test_drain_underflow();
        idle_en = 1'b0;
        test_random_walk(120, 60);
        s_axis_tvalid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
